[sv/rcs_pkg.sv]
package rcs_pkg;

    localparam int ACC_WIDTH_DEF = 32;
    localparam int MAX_DIGITS    = 32;
    localparam int DIGIT_IDX_W   = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int BASE_W        = 6;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_CHAR_W  = 7;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 6'd2;
    localparam logic [BASE_W-1:0] TARGET_BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] TARGET_BASE_MAX   = 6'd36;

    // register select, taken from paddr[2]
    localparam logic REG_SOURCE_BASE = 1'b0;
    localparam logic REG_TARGET_BASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_RD,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic start;
        logic clear;
    } mac_cmd_t;

    typedef struct packed {
        logic load;
        logic resume;
    } div_cmd_t;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_stat_t;

    // '0'-'9' -> 0-9, 'A'-'Z' and 'a'-'z' -> 10-35, anything else -> 0
    function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (ch >= 8'd48 && ch <= 8'd57)
        begin
            d = ch - 8'd48;
        end
        else if (ch >= 8'd65 && ch <= 8'd90)
        begin
            d = ch - 8'd55;
        end
        else if (ch >= 8'd97 && ch <= 8'd122)
        begin
            d = ch - 8'd87;
        end
        return d[BASE_W-1:0];
    endfunction

    function automatic logic [DIGIT_CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [DIGIT_CHAR_W-1:0] c;
        if (d < 6'd10)
        begin
            c = 7'd48 + {1'b0, d};
        end
        else
        begin
            c = 7'd55 + {1'b0, d};
        end
        return c;
    endfunction

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < TARGET_BASE_MIN)
        begin
            r = TARGET_BASE_MIN;
        end
        else if (b > TARGET_BASE_MAX)
        begin
            r = TARGET_BASE_MAX;
        end
        return r;
    endfunction

endpackage

[sv/rcs_if.sv]
interface rcs_char_if;
    logic                        valid;
    logic                        ready;
    logic [rcs_pkg::CHAR_W-1:0]  char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface rcs_digit_if;
    logic                             valid;
    logic                             ready;
    logic [rcs_pkg::DIGIT_CHAR_W-1:0] digit_char;
    logic                             last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

[sv/rcs_ram.sv]
module rcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/rcs_apb_regs.sv]
module rcs_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [rcs_pkg::BASE_W-1:0]        source_base,
    output logic [rcs_pkg::BASE_W-1:0]        target_base
);
    import rcs_pkg::*;

    logic [BASE_W-1:0] source_base_reg, source_base_next;
    logic [BASE_W-1:0] target_base_reg, target_base_next;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];   // byte lanes ignored

    always_comb
    begin
        source_base_next = source_base_reg;
        target_base_next = target_base_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_SOURCE_BASE: source_base_next = pwdata[BASE_W-1:0];
                REG_TARGET_BASE: target_base_next = pwdata[BASE_W-1:0];
                default:         source_base_next = source_base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SOURCE_BASE: prdata = APB_DATA_W'(source_base_reg);
            REG_TARGET_BASE: prdata = APB_DATA_W'(target_base_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_base_reg <= SOURCE_BASE_RESET;
            target_base_reg <= TARGET_BASE_RESET;
        end
        else
        begin
            source_base_reg <= source_base_next;
            target_base_reg <= target_base_next;
        end
    end

    assign source_base = source_base_reg;
    assign target_base = target_base_reg;

endmodule

[sv/rcs_mac.sv]
module rcs_mac #(
    parameter int ACC_WIDTH = rcs_pkg::ACC_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcs_pkg::mac_cmd_t             cmd,
    input  logic [rcs_pkg::BASE_W-1:0]    digit,
    input  logic [rcs_pkg::BASE_W-1:0]    base,
    output logic [ACC_WIDTH-1:0]          acc,
    output logic                          done
);
    import rcs_pkg::*;

    localparam int                IDX_W   = $clog2(BASE_W);
    localparam logic [IDX_W-1:0]  TOP_BIT = IDX_W'(BASE_W - 1);

    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic [ACC_WIDTH-1:0] prod_reg, prod_next;
    logic [BASE_W-1:0]    digit_reg, digit_next;
    logic [IDX_W-1:0]     bit_idx_reg, bit_idx_next;
    logic                 busy_reg, busy_next;
    logic [ACC_WIDTH-1:0] addend;
    logic [ACC_WIDTH-1:0] prod_step;

    // multiply by base one base bit a cycle, MSB first: p = 2p + (bit ? acc : 0)
    assign addend    = base[bit_idx_reg] ? acc_reg : '0;
    assign prod_step = {prod_reg[ACC_WIDTH-2:0], 1'b0} + addend;
    assign done      = busy_reg && (bit_idx_reg == '0);

    always_comb
    begin
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        digit_next   = digit_reg;
        bit_idx_next = bit_idx_reg;
        busy_next    = busy_reg;
        if (cmd.clear)
        begin
            acc_next = '0;
        end
        else if (cmd.start)
        begin
            prod_next    = '0;
            digit_next   = digit;
            bit_idx_next = TOP_BIT;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = prod_step;
            if (bit_idx_reg == '0)
            begin
                acc_next  = prod_step + {{(ACC_WIDTH-BASE_W){1'b0}}, digit_reg};
                busy_next = 1'b0;
            end
            else
            begin
                bit_idx_next = bit_idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        digit_reg   <= digit_next;
        bit_idx_reg <= bit_idx_next;
    end

    assign acc = acc_reg;

endmodule

[sv/rcs_div.sv]
module rcs_div #(
    parameter int ACC_WIDTH = rcs_pkg::ACC_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcs_pkg::div_cmd_t             cmd,
    input  logic [ACC_WIDTH-1:0]          value,
    input  logic [rcs_pkg::BASE_W-1:0]    base,
    output rcs_pkg::div_stat_t            stat,
    output logic [rcs_pkg::BASE_W-1:0]    rem
);
    import rcs_pkg::*;

    localparam int               CNT_W     = $clog2(ACC_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ACC_WIDTH - 1);

    logic [ACC_WIDTH-1:0] quot_reg, quot_next;
    logic [BASE_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BASE_W:0]      trial;
    logic [BASE_W:0]      diff;
    logic                 q_bit;

    // restoring division, one quotient bit a cycle; quotient shifts in
    // behind the dividend so a resume divides the last quotient again
    assign trial = {rem_reg, quot_reg[ACC_WIDTH-1]};
    assign diff  = trial - {1'b0, base};
    assign q_bit = (trial >= {1'b0, base});

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.load || cmd.resume)
        begin
            if (cmd.load)
            begin
                quot_next = value;
            end
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[ACC_WIDTH-2:0], q_bit};
            rem_next  = q_bit ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign stat.done      = done_reg;
    assign stat.quot_zero = (quot_reg == '0);
    assign rem            = rem_reg;

`ifndef SYNTH
    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < base))
        else $error("remainder not below divisor");
`endif

endmodule

[sv/radix_conversion_stream.sv]
// Radix conversion of a character stream.
// char_stream carries one ASCII character per word. Digit characters
// ('0'-'9', 'A'-'Z', 'a'-'z'; anything else counts as 0) are folded into an
// ACC_WIDTH-bit accumulator: acc = acc * source_base + digit, wrapping.
// A newline ends the number: the accumulator is divided by target_base
// (clamped to 2..36) and the digits leave on digit_stream as '0'-'9'/'A'-'Z',
// most significant first, last_digit set on the final one. Empty -> '0'.
// A digit character is folded in by the shift-add unit, which multiplies in
// the 6-bit base one bit per cycle. A newline runs the bit-serial divider
// once per digit, storing each remainder in the digit RAM, and then reads
// the digit RAM back for output. At most 32 digits are kept (least
// significant).
// char_stream.ready is high only between items. A stalled receiver holds the
// output register and the read-back waits; the last digit may still sit in
// the output register while the next character is taken.
// Reset: accumulator cleared, source_base = 10, target_base = 2. The APB
// registers (source_base at 0x0, target_base at 0x4) must be written only while
// the block is idle; the block itself does not enforce this.
module radix_conversion_stream #(
    parameter int ACC_WIDTH = rcs_pkg::ACC_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rcs_char_if.sink                          char_stream,
    rcs_digit_if.source                       digit_stream,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import rcs_pkg::*;

    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(MAX_DIGITS - 1);

    state_t                    state_reg, state_next;
    logic [DIGIT_CNT_W-1:0]    cnt_reg, cnt_next;      // digits produced so far
    logic [DIGIT_IDX_W-1:0]    rd_idx_reg, rd_idx_next; // read-back pointer
    logic                      out_valid_reg, out_valid_next;
    logic [DIGIT_CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                      out_last_reg, out_last_next;

    logic [BASE_W-1:0]         source_base;
    logic [BASE_W-1:0]         target_base;
    logic [BASE_W-1:0]         div_base;
    mac_cmd_t                  mac_cmd;
    logic                      mac_done;
    logic [ACC_WIDTH-1:0]      acc;
    div_cmd_t                  div_cmd;
    div_stat_t                 div_stat;
    logic [BASE_W-1:0]         div_rem;
    logic                      ram_we;
    logic [BASE_W-1:0]         ram_rdata;
    logic                      in_acc;
    logic                      is_newline;
    logic                      out_load;

    rcs_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .source_base (source_base),
        .target_base (target_base)
    );

    rcs_mac #(.ACC_WIDTH(ACC_WIDTH)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .digit (char_value(char_stream.char_in)),
        .base  (source_base),
        .acc   (acc),
        .done  (mac_done)
    );

    assign div_base = clamp_base(target_base);

    rcs_div #(.ACC_WIDTH(ACC_WIDTH)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .value (acc),
        .base  (div_base),
        .stat  (div_stat),
        .rem   (div_rem)
    );

    // digits come out of the divider LS first, go back out MS first
    rcs_ram #(.WIDTH(BASE_W), .DEPTH(MAX_DIGITS)) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[DIGIT_IDX_W-1:0]),
        .wdata (div_rem),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign char_stream.ready = (state_reg == ST_IDLE);
    assign in_acc            = char_stream.valid && char_stream.ready;
    assign is_newline        = (char_stream.char_in == NEWLINE_CHAR);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        mac_cmd     = '0;
        div_cmd     = '0;
        ram_we      = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_newline)
                    begin
                        div_cmd.load  = 1'b1;
                        mac_cmd.clear = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        mac_cmd.start = 1'b1;
                        state_next    = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (div_stat.quot_zero || cnt_reg == LAST_DIGIT)
                    begin
                        rd_idx_next = cnt_reg[DIGIT_IDX_W-1:0];
                        state_next  = ST_RD;
                    end
                    else
                    begin
                        div_cmd.resume = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;   // RAM read latency
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || digit_stream.ready)
                begin
                    out_load = 1'b1;
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = digit_to_char(ram_rdata);
            out_last_next  = (rd_idx_reg == '0);
        end
        else if (digit_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign digit_stream.valid      = out_valid_reg;
    assign digit_stream.digit_char = out_char_reg;
    assign digit_stream.last_digit = out_last_reg;

`ifndef SYNTH
    a_newline_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_newline) |=> (state_reg == ST_DIV))
        else $error("newline did not start conversion");

    a_digit_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_stat.done) |-> (cnt_reg <= LAST_DIGIT))
        else $error("digit store overrun");

    a_last_ends_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && rd_idx_reg == '0) |=>
            (state_reg == ST_IDLE && out_valid_reg && out_last_reg))
        else $error("final digit not flagged or read-back not finished");
`endif

endmodule

[tb/radix_conversion_stream_test.sv]
`timescale 1ns / 1ps

module radix_conversion_stream_test;
    import rcs_pkg::*;

    localparam int ACC_W         = ACC_WIDTH_DEF;
    // Worst case is roughly 370 newlines x 32 digits each, plus output stalls;
    // this limit leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT   = 2_000_000;
    // A digit character keeps the shift-add unit busy without producing a
    // word, so wait this long before touching the registers.
    localparam int CHAR_SETTLE   = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PRESSURE_HOLD = 600;

    localparam logic [APB_ADDR_W-1:0] SOURCE_BASE_ADDR = {REG_SOURCE_BASE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] TARGET_BASE_ADDR = {REG_TARGET_BASE, 2'b00};

    typedef struct packed {
        logic [DIGIT_CHAR_W-1:0] ch;
        logic                    last;
    } digit_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rcs_char_if  char_bus ();
    rcs_digit_if digit_bus ();

    radix_conversion_stream dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_stream  (char_bus),
        .digit_stream (digit_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predictor state: our own copy of the accumulator and both bases.
    logic [ACC_W-1:0]  acc_value;
    logic [BASE_W-1:0] source_base_q;
    logic [BASE_W-1:0] target_base_q;
    digit_word_t       expected_digits[$];

    // Idling knobs, changed per phase. hold_off_left forces a long output stall.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;

    int error_count    = 0;
    int chars_sent     = 0;
    int numbers_sent   = 0;
    int digits_checked = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any hang (lost digit, stuck handshake) ends here.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("TIMEOUT after %0d cycles, %0d digits still pending",
                         cycle_count, expected_digits.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // --------------------------------------------------------------------
    // Predictor
    // --------------------------------------------------------------------

    // Digit weight of a character; anything outside the three ranges is 0.
    function automatic logic [BASE_W-1:0] char_weight(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return BASE_W'(c - "0");
        if (c >= "A" && c <= "Z")
            return BASE_W'(c - "A" + 8'd10);
        if (c >= "a" && c <= "z")
            return BASE_W'(c - "a" + 8'd10);
        return '0;
    endfunction

    // Horner step; the source base is used as is, even 0, 1 or above 36.
    function automatic void fold_char(input logic [CHAR_W-1:0] c);
        acc_value = ACC_W'(acc_value * source_base_q + char_weight(c));
    endfunction

    // Newline: split the accumulator into target-base digits and queue them
    // most significant first. Only the 32 least significant digits survive.
    function automatic void predict_conversion();
        logic [ACC_W-1:0]  rest;
        logic [BASE_W-1:0] radix;
        logic [BASE_W-1:0] rem_digits[MAX_DIGITS];
        logic [BASE_W-1:0] d;
        int                n;
        digit_word_t       w;
        radix = target_base_q;
        if (radix < 2)
            radix = 2;
        else if (radix > 36)
            radix = 36;
        rest = acc_value;
        n    = 0;
        do
        begin
            rem_digits[n] = BASE_W'(rest % radix);
            n++;
            rest = rest / radix;
        end
        while (rest != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            d      = rem_digits[k];
            w.ch   = (d < 10) ? DIGIT_CHAR_W'("0" + d) : DIGIT_CHAR_W'("A" + d - 8'd10);
            w.last = (k == 0);
            expected_digits.push_back(w);
        end
        acc_value = '0;
    endfunction

    // --------------------------------------------------------------------
    // Output side: random ready, long hold-off on request, and the check
    // of every accepted word against the oldest expectation.
    // --------------------------------------------------------------------

    task automatic check_digit(input logic [DIGIT_CHAR_W-1:0] got_char, input logic got_last);
        digit_word_t want;
        if (expected_digits.size() == 0)
        begin
            report_mismatch("digit word with nothing pending", got_char, 0);
            return;
        end
        want = expected_digits.pop_front();
        digits_checked++;
        if (got_char !== want.ch)
            report_mismatch("digit_char", got_char, want.ch);
        if (got_last !== want.last)
            report_mismatch("last_digit", got_last, want.last);
    endtask

    initial
    begin
        digit_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && digit_bus.valid && digit_bus.ready)
                check_digit(digit_bus.digit_char, digit_bus.last_digit);
            if (hold_off_left > 0)
            begin
                digit_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                digit_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // --------------------------------------------------------------------
    // Input side and configuration port
    // --------------------------------------------------------------------

    // Offer one character, idling first at random, and predict on acceptance.
    // valid stays high between back-to-back words.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= c;
        do
            @(posedge clk);
        while (!char_bus.ready);
        chars_sent++;
        if (c == NEWLINE_CHAR)
        begin
            predict_conversion();
            numbers_sent++;
        end
        else
        begin
            fold_char(c);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // One APB transfer: setup, access until pready, then idle with psel low so
    // that back-to-back transfers never set and clear psel in one step.
    task automatic apb_access(input logic [APB_ADDR_W-1:0] addr, input logic wr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [BASE_W-1:0] want, input string name);
        logic [APB_DATA_W-1:0] rd;
        apb_access(addr, 1'b0, '0, rd);
        if (rd[BASE_W-1:0] !== want)
            report_mismatch({name, " read-back"}, rd[BASE_W-1:0], want);
    endtask

    // Block is idle once every queued digit has come out and any digit
    // character still in the multiplier has had time to finish.
    task automatic wait_idle();
        char_bus.valid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (CHAR_SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
        logic [APB_DATA_W-1:0] discard;
        wait_idle();
        apb_access(SOURCE_BASE_ADDR, 1'b1, APB_DATA_W'(src), discard);
        apb_access(TARGET_BASE_ADDR, 1'b1, APB_DATA_W'(tgt), discard);
        source_base_q = src;
        target_base_q = tgt;
        check_register(SOURCE_BASE_ADDR, src, "source_base");
        check_register(TARGET_BASE_ADDR, tgt, "target_base");
        settings_used++;
    endtask

    // --------------------------------------------------------------------
    // Random stimulus helpers
    // --------------------------------------------------------------------

    // Mostly legal bases, now and then any 6-bit value.
    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(9) == 0)
            return BASE_W'($urandom_range(63));
        return BASE_W'($urandom_range(2, 36));
    endfunction

    // Mostly digits valid for the current base in either letter case, some
    // out-of-range digits, and some raw bytes (which may even be a newline).
    function automatic logic [CHAR_W-1:0] random_digit_char();
        int d;
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return CHAR_W'($urandom_range(255));
        if (source_base_q >= 2 && source_base_q <= 36 && roll < 90)
            d = $urandom_range(source_base_q - 1);
        else
            d = $urandom_range(35);
        if (d < 10)
            return CHAR_W'("0" + d);
        if ($urandom_range(1))
            return CHAR_W'("a" + d - 10);
        return CHAR_W'("A" + d - 10);
    endfunction

    // --------------------------------------------------------------------
    // Tests
    // --------------------------------------------------------------------

    // Reset values of both registers, an empty number, and 7 to binary.
    task automatic test_reset_values();
        check_register(SOURCE_BASE_ADDR, SOURCE_BASE_RESET, "source_base");
        check_register(TARGET_BASE_ADDR, TARGET_BASE_RESET, "target_base");
        send_text("\n7\n");
    endtask

    // Every digit class with some of its edges, non-digit bytes counting as zero,
    // all in base 36 both ways; the value wraps past 32 bits.
    task automatic test_character_classes();
        configure(6'd36, 6'd36);
        send_char("z");
        send_char(8'h00);
        send_char("A");
        send_char("9");
        send_char(8'hFF);
        send_char("a");
        send_char("/");
        send_char(NEWLINE_CHAR);
    endtask

    // Base extremes: all-ones value in binary gives the full 32 digits with
    // the target clamped up; a zero source base; oversize bases both sides.
    task automatic test_base_extremes();
        configure(6'd16, 6'd0);
        send_text("FFFFFFFF\n");
        configure(6'd0, 6'd1);
        send_text("5a\n");
        configure(6'd63, 6'd37);
        send_text("Zz\n");
    endtask

    // Output held off for a long stretch while characters keep coming: the
    // output register fills, the read-back waits and the input stalls.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(6'd36, 6'd63);
        hold_off_left = PRESSURE_HOLD;
        send_text("ZZZZ\n1\n\n");
    endtask

    // One phase of random numbers, each closed by a newline, under one
    // random setting and one idling mix. Lengths are mostly short, with a
    // few long enough to wrap the accumulator.
    task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct);
        int stop_at;
        int len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        configure(pick_base(), pick_base());
        stop_at = chars_sent + n_items;
        while (chars_sent < stop_at)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
            repeat (len)
                send_char(random_digit_char());
            send_char(NEWLINE_CHAR);
        end
    endtask

    task automatic test_random_traffic();
        for (int pass = 0; pass < 2; pass++)
        begin
            run_random_phase(40, 0, 0);
            run_random_phase(40, 65, 0);
            run_random_phase(40, 0, 65);
            run_random_phase(40, 17, 17);
        end
    endtask

    // --------------------------------------------------------------------
    // Sequence
    // --------------------------------------------------------------------

    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        char_bus.valid   <= 1'b0;
        char_bus.char_in <= '0;
        acc_value     = '0;
        source_base_q = SOURCE_BASE_RESET;
        target_base_q = TARGET_BASE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_character_classes();
        test_base_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters (%0d numbers) under %0d base settings,",
                 chars_sent, numbers_sent, settings_used);
        $display("checked %0d digit words incl. a %0d-cycle output hold-off.",
                 digits_checked, PRESSURE_HOLD);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
